@@ rtl/core/dnp_pkg.sv @@
package dnp_pkg;

    localparam int MAX_DIGITS_DEF     = 18;
    localparam int EXPONENT_LIMIT_DEF = 9999;

    localparam int SIG_W      = 60;
    localparam int DEC_EXP_W  = 16;
    localparam int COUNT_W    = 16;
    localparam int EXP_ACC_W  = 14;
    localparam int EXP_SHIFT_W = 15;
    localparam int EXP_SUM_W  = 17;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_E_UP  = 8'h45;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_INT,
        PH_FRAC,
        PH_EXP_SIGN,
        PH_EXP_DIG
    } t_phase;

    typedef struct packed {
        logic [SIG_W-1:0]            significand;
        logic signed [DEC_EXP_W-1:0] decimal_exponent;
        logic                        is_negative;
        logic [COUNT_W-1:0]          chars_used;
        logic                        digits_dropped;
    } t_result;

    // elaboration-time power of ten
    function automatic logic [SIG_W-1:0] pow10(input int n);
        logic [SIG_W-1:0] v;
        v = SIG_W'(1);
        for (int k = 0; k < n; k++) begin
            v = SIG_W'(v * SIG_W'(10));
        end
        return v;
    endfunction

endpackage

@@ rtl/core/dnp_core.sv @@
module dnp_core #(
    parameter int MAX_DIGITS     = dnp_pkg::MAX_DIGITS_DEF,
    parameter int EXPONENT_LIMIT = dnp_pkg::EXPONENT_LIMIT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_char_code,
    input  logic             i_starts_number,
    input  logic             i_ends_text,
    output logic             o_res_valid,
    output dnp_pkg::t_result o_res
);
    import dnp_pkg::*;

    localparam int HW = $clog2(MAX_DIGITS + 1);
    localparam logic [HW-1:0] MAX_HELD = HW'(MAX_DIGITS);
    localparam logic signed [EXP_SHIFT_W-1:0] LIM_S = EXP_SHIFT_W'(EXPONENT_LIMIT);
    localparam logic [EXP_ACC_W-1:0] LIM_A = EXP_ACC_W'(EXPONENT_LIMIT);
    localparam logic signed [EXP_SHIFT_W-1:0] SHIFT_ONE = EXP_SHIFT_W'(1);

    t_phase                        r_phase, n_phase, b_phase;
    logic [SIG_W-1:0]              r_acc, n_acc, b_acc;
    logic [HW-1:0]                 r_held, n_held, b_held;
    logic signed [EXP_SHIFT_W-1:0] r_shift, n_shift, b_shift;
    logic [EXP_ACC_W-1:0]          r_eacc, n_eacc, b_eacc;
    logic                          r_neg, n_neg, b_neg;
    logic                          r_eneg, n_eneg, b_eneg;
    logic [COUNT_W-1:0]            r_count, n_count, b_count;
    logic                          r_loss, n_loss, b_loss;

    logic                   active, taken, emit;
    logic                   is_dig, is_e, is_sign;
    logic [3:0]             dval;
    logic                   mant, frac, edig, do_up, do_down;
    logic [EXP_SUM_W-1:0]   ev;
    logic signed [DEC_EXP_W-1:0] e_read;

    assign is_dig  = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    assign dval    = is_dig ? 4'(i_char_code - CH_ZERO) : 4'd0;
    assign is_e    = (i_char_code == CH_E_LO) || (i_char_code == CH_E_UP);
    assign is_sign = (i_char_code == CH_PLUS) || (i_char_code == CH_MINUS);

    always_comb begin
        // a start clears the number before this character is looked at
        b_phase = r_phase;
        b_acc   = r_acc;
        b_held  = r_held;
        b_shift = r_shift;
        b_eacc  = r_eacc;
        b_neg   = r_neg;
        b_eneg  = r_eneg;
        b_count = r_count;
        b_loss  = r_loss;
        if (i_starts_number) begin
            b_phase = PH_INT;
            b_acc   = '0;
            b_held  = '0;
            b_shift = '0;
            b_eacc  = '0;
            b_neg   = 1'b0;
            b_eneg  = 1'b0;
            b_count = '0;
            b_loss  = 1'b0;
        end
        active = i_starts_number || (r_phase != PH_IDLE);

        n_phase = b_phase;
        n_acc   = b_acc;
        n_held  = b_held;
        n_shift = b_shift;
        n_eacc  = b_eacc;
        n_neg   = b_neg;
        n_eneg  = b_eneg;
        n_count = b_count;
        n_loss  = b_loss;
        taken   = 1'b0;
        mant    = 1'b0;
        frac    = 1'b0;
        edig    = 1'b0;
        do_up   = 1'b0;
        do_down = 1'b0;
        ev      = '0;

        if (i_starts_number && is_sign) begin
            taken = 1'b1;
            if (i_char_code == CH_MINUS) n_neg = 1'b1;
        end else begin
            unique case (b_phase)
                PH_INT: begin
                    if (is_dig) begin
                        taken = 1'b1;
                        mant  = 1'b1;
                    end else if (i_char_code == CH_DOT) begin
                        taken   = 1'b1;
                        n_phase = PH_FRAC;
                    end else if (is_e) begin
                        taken   = 1'b1;
                        n_phase = PH_EXP_SIGN;
                    end
                end
                PH_FRAC: begin
                    if (is_dig) begin
                        taken = 1'b1;
                        mant  = 1'b1;
                        frac  = 1'b1;
                    end else if (is_e) begin
                        taken   = 1'b1;
                        n_phase = PH_EXP_SIGN;
                    end
                end
                PH_EXP_SIGN: begin
                    if (is_sign) begin
                        taken   = 1'b1;
                        n_phase = PH_EXP_DIG;
                        if (i_char_code == CH_MINUS) n_eneg = 1'b1;
                    end else if (is_dig) begin
                        taken   = 1'b1;
                        edig    = 1'b1;
                        n_phase = PH_EXP_DIG;
                    end
                end
                PH_EXP_DIG: begin
                    if (is_dig) begin
                        taken = 1'b1;
                        edig  = 1'b1;
                    end
                end
                PH_IDLE: ;
                default: ;
            endcase
        end

        if (mant) begin
            if (b_held == '0 && dval == 4'd0) begin
                // leading zeros hold no digit place
                do_down = frac;
            end else if (b_held < MAX_HELD) begin
                n_acc   = (b_acc << 3) + (b_acc << 1) + SIG_W'(dval);
                n_held  = HW'(b_held + 1'b1);
                do_down = frac;
            end else begin
                if (dval != 4'd0) n_loss = 1'b1;
                do_up = !frac;
            end
        end

        if (do_up) begin
            if (b_shift < LIM_S) n_shift = EXP_SHIFT_W'(b_shift + SHIFT_ONE);
            else n_loss = 1'b1;
        end
        if (do_down) begin
            if (b_shift > -LIM_S) n_shift = EXP_SHIFT_W'(b_shift - SHIFT_ONE);
            else n_loss = 1'b1;
        end

        if (edig) begin
            ev = (EXP_SUM_W'(b_eacc) << 3) + (EXP_SUM_W'(b_eacc) << 1) + EXP_SUM_W'(dval);
            if (ev > EXP_SUM_W'(EXPONENT_LIMIT)) begin
                n_eacc = LIM_A;
                n_loss = 1'b1;
            end else begin
                n_eacc = ev[EXP_ACC_W-1:0];
            end
        end

        if (taken && (b_count != '1)) n_count = COUNT_W'(b_count + 1'b1);

        emit = active && (!taken || i_ends_text);
        if (emit) n_phase = PH_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= '0;
            r_held  <= '0;
            r_shift <= '0;
            r_eacc  <= '0;
            r_neg   <= 1'b0;
            r_eneg  <= 1'b0;
            r_count <= '0;
            r_loss  <= 1'b0;
        end else if (i_fire && active) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_held  <= n_held;
            r_shift <= n_shift;
            r_eacc  <= n_eacc;
            r_neg   <= n_neg;
            r_eneg  <= n_eneg;
            r_count <= n_count;
            r_loss  <= n_loss;
        end
    end

    assign e_read = n_eneg ? -$signed({2'b00, n_eacc}) : $signed({2'b00, n_eacc});

    assign o_res_valid            = i_fire && emit;
    assign o_res.significand      = n_acc;
    assign o_res.decimal_exponent = DEC_EXP_W'(e_read + $signed({n_shift[EXP_SHIFT_W-1], n_shift}));
    assign o_res.is_negative      = n_neg;
    assign o_res.chars_used       = n_count;
    assign o_res.digits_dropped   = n_loss;

endmodule

@@ rtl/core/dnp_out_buf.sv @@
module dnp_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load_valid,
    input  dnp_pkg::t_result i_load,
    output logic             o_can_load,
    input  logic             i_stall,
    output logic             o_valid,
    output dnp_pkg::t_result o_res
);
    import dnp_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_can_load = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load_valid) begin
            r_res <= i_load;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

@@ rtl/core/decimal_number_text_parser.sv @@
// a request is held in the input register, then its result is registered in the output buffer
// throughput: one character per cycle while o_stall is low; the digit and exponent update is combinational
// while a finished result waits on i_stall the input register holds one request, then stalls
// reset: synchronous active-low i_rst_n clears the parse state and both valid flags;
// the parser then waits for a character with i_starts_number set
module decimal_number_text_parser #(
    parameter int MAX_DIGITS     = dnp_pkg::MAX_DIGITS_DEF,
    parameter int EXPONENT_LIMIT = dnp_pkg::EXPONENT_LIMIT_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_stall,
    input  logic [7:0]                               i_char_code,
    input  logic                                     i_starts_number,
    input  logic                                     i_ends_text,
    output logic                                     o_valid,
    input  logic                                     i_stall,
    output logic [dnp_pkg::SIG_W-1:0]                o_significand,
    output logic signed [dnp_pkg::DEC_EXP_W-1:0]     o_decimal_exponent,
    output logic                                     o_is_negative,
    output logic [dnp_pkg::COUNT_W-1:0]              o_chars_used,
    output logic                                     o_digits_dropped
);
    import dnp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_start;
    logic       r_last;
    logic       accept, fire, can_load, res_valid;
    t_result    res, out_res;

    assign fire    = r_in_valid && can_load;
    assign o_stall = r_in_valid && !can_load;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_char  <= i_char_code;
            r_start <= i_starts_number;
            r_last  <= i_ends_text;
        end
    end

    dnp_core #(
        .MAX_DIGITS     (MAX_DIGITS),
        .EXPONENT_LIMIT (EXPONENT_LIMIT)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_char_code     (r_char),
        .i_starts_number (r_start),
        .i_ends_text     (r_last),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    dnp_out_buf u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (res_valid),
        .i_load       (res),
        .o_can_load   (can_load),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_res        (out_res)
    );

    assign o_significand      = out_res.significand;
    assign o_decimal_exponent = out_res.decimal_exponent;
    assign o_is_negative      = out_res.is_negative;
    assign o_chars_used       = out_res.chars_used;
    assign o_digits_dropped   = out_res.digits_dropped;

endmodule

@@ rtl/core/dnp_checker.sv @@
module dnp_checker #(
    parameter int MAX_DIGITS     = dnp_pkg::MAX_DIGITS_DEF,
    parameter int EXPONENT_LIMIT = dnp_pkg::EXPONENT_LIMIT_DEF
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 o_stall,
    input logic                                 o_valid,
    input logic                                 i_stall,
    input logic [dnp_pkg::SIG_W-1:0]            o_significand,
    input logic signed [dnp_pkg::DEC_EXP_W-1:0] o_decimal_exponent,
    input logic                                 o_is_negative,
    input logic [dnp_pkg::COUNT_W-1:0]          o_chars_used,
    input logic                                 o_digits_dropped
);
    import dnp_pkg::*;

    localparam logic [SIG_W-1:0] SIG_BOUND = pow10(MAX_DIGITS);
    localparam logic signed [DEC_EXP_W-1:0] EXP_BOUND = DEC_EXP_W'(2 * EXPONENT_LIMIT);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_significand)
            && $stable(o_decimal_exponent) && $stable(o_is_negative)
            && $stable(o_chars_used) && $stable(o_digits_dropped))
        else $error("result changed while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("valid flags not cleared by reset");

    // the input side only stalls behind a full, stalled output register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("request stalled without output back-pressure");

    a_sig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_significand < SIG_BOUND)
        else $error("significand holds too many digits");

    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_decimal_exponent <= EXP_BOUND && o_decimal_exponent >= -EXP_BOUND)
        else $error("decimal exponent out of range");

endmodule

bind decimal_number_text_parser dnp_checker #(
    .MAX_DIGITS     (MAX_DIGITS),
    .EXPONENT_LIMIT (EXPONENT_LIMIT)
) u_dnp_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_stall            (o_stall),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_significand      (o_significand),
    .o_decimal_exponent (o_decimal_exponent),
    .o_is_negative      (o_is_negative),
    .o_chars_used       (o_chars_used),
    .o_digits_dropped   (o_digits_dropped)
);

@@ tb/number_parse_checker.sv @@
module number_parse_checker
    import dnp_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  logic                        i_req_stall,
    input  logic [7:0]                  i_char_code,
    input  logic                        i_starts_number,
    input  logic                        i_ends_text,
    input  logic                        i_res_valid,
    input  logic                        i_res_stall,
    input  logic [SIG_W-1:0]            i_significand,
    input  logic signed [DEC_EXP_W-1:0] i_decimal_exponent,
    input  logic                        i_is_negative,
    input  logic [COUNT_W-1:0]          i_chars_used,
    input  logic                        i_digits_dropped,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_numbers_checked,
    output int                          o_numbers_lossy
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXD = MAX_DIGITS_DEF;
    localparam int ELIM = EXPONENT_LIMIT_DEF;

    t_phase                         phase;
    logic [SIG_W-1:0]               digit_acc;
    logic [4:0]                     held;
    logic signed [EXP_SHIFT_W-1:0]  shift;
    logic [EXP_ACC_W-1:0]           exp_acc;
    logic                           num_neg;
    logic                           exp_neg;
    logic [COUNT_W-1:0]             count;
    logic                           lost;
    t_result                        number_q[$];

    function automatic void clear_number();
        digit_acc = '0;
        held      = '0;
        shift     = '0;
        exp_acc   = '0;
        num_neg   = 1'b0;
        exp_neg   = 1'b0;
        count     = '0;
        lost      = 1'b0;
    endfunction

    function automatic void nudge_shift(input bit up);
        if (up) begin
            if (shift < ELIM) shift = shift + 1'b1;
            else lost = 1'b1;
        end else begin
            if (shift > -ELIM) shift = shift - 1'b1;
            else lost = 1'b1;
        end
    endfunction

    function automatic void add_mantissa_digit(input logic [3:0] d, input bit frac);
        if (held == 0 && d == 0) begin
            // zeros ahead of the first kept digit take no digit place
            if (frac) nudge_shift(1'b0);
        end else if (held < MAXD) begin
            digit_acc = digit_acc * SIG_W'(10) + SIG_W'(d);
            held      = held + 1'b1;
            if (frac) nudge_shift(1'b0);
        end else begin
            if (d != 0) lost = 1'b1;
            if (!frac) nudge_shift(1'b1);
        end
    endfunction

    function automatic void add_exponent_digit(input logic [3:0] d);
        int v;
        v = int'(exp_acc) * 10 + int'(d);
        if (v > ELIM) begin
            v    = ELIM;
            lost = 1'b1;
        end
        exp_acc = EXP_ACC_W'(v);
    endfunction

    function automatic bit take_char(input logic [7:0] c, input bit first);
        bit         dig;
        bit         is_e;
        logic [3:0] d;
        dig  = (c >= CH_ZERO) && (c <= CH_NINE);
        d    = dig ? 4'(c - CH_ZERO) : 4'd0;
        is_e = (c == CH_E_LO) || (c == CH_E_UP);
        if (first && (c == CH_PLUS || c == CH_MINUS)) begin
            if (c == CH_MINUS) num_neg = 1'b1;
            return 1'b1;
        end
        case (phase)
            PH_INT: begin
                if (dig) begin
                    add_mantissa_digit(d, 1'b0);
                    return 1'b1;
                end
                if (c == CH_DOT) begin
                    phase = PH_FRAC;
                    return 1'b1;
                end
                if (is_e) begin
                    phase = PH_EXP_SIGN;
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_FRAC: begin
                if (dig) begin
                    add_mantissa_digit(d, 1'b1);
                    return 1'b1;
                end
                if (is_e) begin
                    phase = PH_EXP_SIGN;
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_EXP_SIGN: begin
                if (c == CH_PLUS || c == CH_MINUS) begin
                    if (c == CH_MINUS) exp_neg = 1'b1;
                    phase = PH_EXP_DIG;
                    return 1'b1;
                end
                if (dig) begin
                    add_exponent_digit(d);
                    phase = PH_EXP_DIG;
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_EXP_DIG: begin
                if (dig) begin
                    add_exponent_digit(d);
                    return 1'b1;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void close_number();
        t_result r;
        int      e;
        e = int'(exp_acc);
        if (exp_neg) e = -e;
        e = e + int'(shift);
        r.significand      = digit_acc;
        r.decimal_exponent = DEC_EXP_W'(e);
        r.is_negative      = num_neg;
        r.chars_used       = count;
        r.digits_dropped   = lost;
        number_q.push_back(r);
        phase = PH_IDLE;
    endfunction

    function automatic void parse_char(input logic [7:0] c, input bit start, input bit last);
        bit taken;
        if (start || phase != PH_IDLE) begin
            // a new start drops whatever number was open
            if (start) begin
                clear_number();
                phase = PH_INT;
            end
            taken = take_char(c, start);
            if (!taken) begin
                close_number();
            end else begin
                if (count != '1) count = count + 1'b1;
                if (last) close_number();
            end
        end
    endfunction

    function automatic void check_number();
        t_result want;
        bit      bad;
        if (number_q.size() == 0) begin
            $error("result with no number pending: significand %0d, exponent %0d",
                   i_significand, i_decimal_exponent);
            o_fail_count++;
        end else begin
            want = number_q.pop_front();
            bad  = 1'b0;
            if (i_significand !== want.significand) begin
                $error("significand: expected %0d, got %0d", want.significand, i_significand);
                bad = 1'b1;
            end
            if (i_decimal_exponent !== want.decimal_exponent) begin
                $error("decimal_exponent: expected %0d, got %0d",
                       want.decimal_exponent, i_decimal_exponent);
                bad = 1'b1;
            end
            if (i_is_negative !== want.is_negative) begin
                $error("is_negative: expected %0d, got %0d", want.is_negative, i_is_negative);
                bad = 1'b1;
            end
            if (i_chars_used !== want.chars_used) begin
                $error("chars_used: expected %0d, got %0d", want.chars_used, i_chars_used);
                bad = 1'b1;
            end
            if (i_digits_dropped !== want.digits_dropped) begin
                $error("digits_dropped: expected %0d, got %0d",
                       want.digits_dropped, i_digits_dropped);
                bad = 1'b1;
            end
            if (bad) o_fail_count++;
            o_numbers_checked++;
            if (want.digits_dropped) o_numbers_lossy++;
        end
    endfunction

    initial begin
        o_fail_count      = 0;
        o_pending         = 0;
        o_numbers_checked = 0;
        o_numbers_lossy   = 0;
        phase             = PH_IDLE;
        clear_number();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase = PH_IDLE;
            clear_number();
            number_q.delete();
        end else begin
            if (i_res_valid && !i_res_stall) check_number();
            if (i_req_valid && !i_req_stall) parse_char(i_char_code, i_starts_number, i_ends_text);
        end
        o_pending = number_q.size();
    end

endmodule

@@ tb/testbench.sv @@
module testbench;
    import dnp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_CHARS   = 440;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        req_valid;
    logic                        req_stall;
    logic [7:0]                  char_code;
    logic                        starts_number;
    logic                        ends_text;
    logic                        res_valid;
    logic                        res_stall;
    logic [SIG_W-1:0]            significand;
    logic signed [DEC_EXP_W-1:0] decimal_exponent;
    logic                        is_negative;
    logic [COUNT_W-1:0]          chars_used;
    logic                        digits_dropped;

    int fail_count;
    int pending;
    int numbers_checked;
    int numbers_lossy;
    int chars_sent;
    int random_chars;
    int idle_cycles;
    bit quiet;
    bit gaps_on;

    always #5 i_clk = ~i_clk;

    decimal_number_text_parser u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (req_valid),
        .o_stall            (req_stall),
        .i_char_code        (char_code),
        .i_starts_number    (starts_number),
        .i_ends_text        (ends_text),
        .o_valid            (res_valid),
        .i_stall            (res_stall),
        .o_significand      (significand),
        .o_decimal_exponent (decimal_exponent),
        .o_is_negative      (is_negative),
        .o_chars_used       (chars_used),
        .o_digits_dropped   (digits_dropped)
    );

    number_parse_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req_valid        (req_valid),
        .i_req_stall        (req_stall),
        .i_char_code        (char_code),
        .i_starts_number    (starts_number),
        .i_ends_text        (ends_text),
        .i_res_valid        (res_valid),
        .i_res_stall        (res_stall),
        .i_significand      (significand),
        .i_decimal_exponent (decimal_exponent),
        .i_is_negative      (is_negative),
        .i_chars_used       (chars_used),
        .i_digits_dropped   (digits_dropped),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_numbers_checked  (numbers_checked),
        .o_numbers_lossy    (numbers_lossy)
    );

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic send_char(input logic [7:0] c, input bit s, input bit e);
        if (!quiet && gaps_on && $urandom_range(0, 3) == 0) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        req_valid     = 1'b1;
        char_code     = c;
        starts_number = s;
        ends_text     = e;
        @(posedge i_clk);
        while (req_stall) @(posedge i_clk);
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string str, input bit first, input bit last_ends);
        for (int i = 0; i < str.len(); i++) begin
            send_char(str[i], first && i == 0, last_ends && i == str.len() - 1);
        end
    endtask

    function automatic int pick_len();
        return ($urandom_range(0, 3) == 0) ? int'($urandom_range(15, 24))
                                           : int'($urandom_range(0, 4));
    endfunction

    function automatic void push_digits(ref logic [7:0] q[$], input int n);
        for (int i = 0; i < n; i++) q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    endfunction

    task automatic send_random_number();
        logic [7:0] text[$];
        logic [7:0] stop_char;
        int         ending;
        int         keep;
        bit         end_on_last;
        bit         has_stop;
        gaps_on = ($urandom_range(0, 2) != 0);
        case ($urandom_range(0, 2))
            0: text.push_back(CH_PLUS);
            1: text.push_back(CH_MINUS);
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) text.push_back(CH_ZERO);
        push_digits(text, pick_len());
        if ($urandom_range(0, 1)) begin
            text.push_back(CH_DOT);
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) text.push_back(CH_ZERO);
            push_digits(text, pick_len());
        end
        if ($urandom_range(0, 2) == 0) begin
            text.push_back($urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
            case ($urandom_range(0, 2))
                0: text.push_back(CH_PLUS);
                1: text.push_back(CH_MINUS);
                default: ;
            endcase
            push_digits(text, $urandom_range(0, 6));
        end
        if (text.size() == 0) push_digits(text, 1);

        ending      = $urandom_range(0, 9);
        end_on_last = (ending <= 3);
        has_stop    = (ending >= 4 && ending != 7);
        case ($urandom_range(0, 4))
            0: stop_char = 8'h00;
            1: stop_char = " ";
            2: stop_char = ",";
            3: stop_char = "x";
            default: stop_char = 8'($urandom_range(0, 255));
        endcase
        // cut short: the next number's start lands while this one is open
        if (ending == 7) begin
            keep = $urandom_range(1, text.size());
            text = text[0:keep-1];
        end

        foreach (text[i]) begin
            send_char(text[i], i == 0, end_on_last && i == text.size() - 1);
        end
        random_chars += text.size();
        if (has_stop) begin
            send_char(stop_char, 1'b0, 1'($urandom_range(0, 1)));
            random_chars++;
        end
        if (ending != 7 && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                send_char(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
                random_chars++;
            end
        end
    endtask

    // result side stall: bursts of random length between runs of free flow
    initial begin
        res_stall = 1'b0;
        forever begin
            if (quiet) begin
                res_stall = 1'b0;
                @(negedge i_clk);
            end else begin
                repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12)) @(negedge i_clk);
                if (!quiet) begin
                    res_stall = 1'b1;
                    repeat ($urandom_range(1, 9)) @(negedge i_clk);
                    res_stall = 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request or result moved for %0d cycles", idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        req_valid     = 1'b0;
        char_code     = '0;
        starts_number = 1'b0;
        ends_text     = 1'b0;
        quiet         = 1'b0;
        gaps_on       = 1'b1;
        chars_sent    = 0;
        random_chars  = 0;
        idle_cycles   = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: full grammar, idle noise, nul stop, lone sign and dot, restart while open
        send_text("-1.5e+3", 1'b1, 1'b1);
        send_char("q", 1'b0, 1'b1);
        send_text("+007.", 1'b1, 1'b0);
        send_char(8'h00, 1'b0, 1'b0);
        send_text("-e5", 1'b1, 1'b0);
        send_text("9E-", 1'b1, 1'b0);
        send_char(",", 1'b0, 1'b0);
        send_text(".", 1'b1, 1'b1);
        send_text("-", 1'b1, 1'b1);
        send_char(8'hFF, 1'b1, 1'b0);

        while (random_chars < RANDOM_CHARS) send_random_number();

        // long numbers: integer digits past the kept ones, deep fraction zeros, no idling
        quiet = 1'b1;
        send_char("1", 1'b1, 1'b0);
        repeat (30) send_char("7", 1'b0, 1'b0);
        send_text("e5", 1'b0, 1'b1);
        send_text("-0.", 1'b1, 1'b0);
        repeat (25) send_char(CH_ZERO, 1'b0, 1'b0);
        send_char("3", 1'b0, 1'b1);
        req_valid = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("sent %0d characters; checked %0d numbers, %0d of them with digits dropped",
                 chars_sent, numbers_checked, numbers_lossy);
        $display("covered signs, fractions, exponents, restarts, dropped digits and exponent clamping");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/dnp_pkg.sv
rtl/core/dnp_core.sv
rtl/core/dnp_out_buf.sv
rtl/core/decimal_number_text_parser.sv
rtl/core/dnp_checker.sv
tb/number_parse_checker.sv
tb/testbench.sv
